// File: sv/whn_pkg.sv
package whn_pkg;

   // field and accumulator widths
   localparam int DATA_W       = 16;
   localparam int ACC_W        = 40;
   localparam int BIN_INDEX_W  = 6;
   localparam int CSR_INDEX_W  = 3;
   localparam int BINS_DEFAULT = 64;

   // shared divider: 17 quotient bits cover both the bin choice and a full share
   localparam int DIV_Q_W     = 17;
   localparam int DIV_STEPS   = 17;
   localparam int DIV_CNT_W   = 5;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   // register reset values
   localparam logic [DATA_W-1:0] MASK_BITS_RESET  = 16'd0;
   localparam logic [DATA_W-1:0] MIN_PHOTOZ_RESET = 16'd0;
   localparam logic [DATA_W-1:0] MAX_PHOTOZ_RESET = 16'd65535;
   localparam logic [DATA_W-1:0] HIST_START_RESET = 16'd0;
   localparam logic [DATA_W-1:0] BIN_WIDTH_RESET  = 16'd205;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MASK_BITS  = 3'd0,
      CSR_MIN_PHOTOZ = 3'd1,
      CSR_MAX_PHOTOZ = 3'd2,
      CSR_HIST_START = 3'd3,
      CSR_BIN_WIDTH  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_DIV,
      ST_ROW_ADD,
      ST_OUT_READ,
      ST_OUT_LOAD,
      ST_OUT_DIV,
      ST_OUT_SEND
   } state_type;

   // divider command: load remainder, dividend bits and divisor, then run
   typedef struct packed {
      logic               start;
      logic [ACC_W-1:0]   rem_init;
      logic [DIV_Q_W-1:0] dividend;
      logic [ACC_W-1:0]   divisor;
   } div_cmd_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } store_cmd_type;

   // add a weight to an accumulator, stopping at the top
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [DATA_W-1:0] wt);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + {{(ACC_W-DATA_W+1){1'b0}}, wt};
      return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
   endfunction

endpackage

// File: sv/whn_divider.sv
module whn_divider
   import whn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_cmd_type        cmd,
   output logic               done,
   output logic [DIV_Q_W-1:0] quotient
);

   logic [ACC_W-1:0]     rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [ACC_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [ACC_W:0]       trial;
   logic [ACC_W:0]       diff;

   // one restoring step: bring in the next dividend bit and try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_Q_W-1]};
      diff  = trial - {1'b0, divisor_ff};
   end

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      run_in     = run_ff;
      done_in    = 1'b0;
      if (cmd.start) begin
         rem_in     = cmd.rem_init;
         quo_in     = cmd.dividend;
         divisor_in = cmd.divisor;
         count_in   = DIV_CNT_W'(DIV_STEPS);
         run_in     = 1'b1;
      end else if (run_ff) begin
         if (diff[ACC_W]) begin
            rem_in = trial[ACC_W-1:0];
            quo_in = {quo_ff[DIV_Q_W-2:0], 1'b0};
         end else begin
            rem_in = diff[ACC_W-1:0];
            quo_in = {quo_ff[DIV_Q_W-2:0], 1'b1};
         end
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // a finished division never coincides with a running one
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("divider done while still running");

   // a start loads the divider with the full step count and sets it running
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> run_ff && count_ff == DIV_CNT_W'(DIV_STEPS))
      else $error("divider did not load on start");

   // the remainder stays below the divisor while running
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> rem_ff < divisor_ff)
      else $error("divider remainder bound");

endmodule

// File: sv/whn_bin_store.sv
module whn_bin_store
   import whn_pkg::*;
#(
   parameter int BINS = BINS_DEFAULT
)
(
   input  logic                                clock,
   input  logic                                reset,
   input  store_cmd_type                       cmd,
   input  logic [(BINS > 1 ? $clog2(BINS) : 1)-1:0] rd_addr,
   input  logic [(BINS > 1 ? $clog2(BINS) : 1)-1:0] wr_addr,
   input  logic [ACC_W-1:0]                    wr_data,
   output logic [ACC_W-1:0]                    rd_data
);

   logic [ACC_W-1:0] mem [BINS];
   logic [BINS-1:0]  valid_ff;
   logic [ACC_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // valid bits: an entry not written since the last clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

   // clear and write are never asked for together
   a_no_clear_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear && cmd.wr_en))
      else $error("bin store cleared and written in one cycle");

   // after a clear every entry reads as empty
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> valid_ff == '0)
      else $error("bin store not empty after clear");

   // a write marks its entry
   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en && !cmd.clear |=> valid_ff[$past(wr_addr)])
      else $error("bin store write not marked valid");

endmodule

// File: sv/weighted_histogram_normalizer.sv
// A kept row is accepted, divided by the bin width, its bin read and its weight added.
// A row marked last then emits BINS results, each bin read and divided by a nonzero total.
// The shared 17-step divider serves rows and results; a new row is taken only while idle.
// busy is high for a kept row and a last row's results; results cannot be stalled.
// Synchronous reset clears the sums, the total, and restores register defaults.
module weighted_histogram_normalizer
   import whn_pkg::*;
#(
   parameter int BINS = BINS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   // requests
   input  logic                   start,
   output logic                   busy,
   input  logic [DATA_W-1:0]      req_spec_z,
   input  logic [DATA_W-1:0]      req_photo_z,
   input  logic [DATA_W-1:0]      req_weight,
   input  logic [DATA_W-1:0]      req_flag_bits,
   input  logic                   req_last_item,
   // results
   output logic                   rsp_strobe,
   output logic [BIN_INDEX_W-1:0] rsp_bin_index,
   output logic [DATA_W-1:0]      rsp_fraction,
   output logic                   rsp_total_zero,
   output logic                   rsp_last_bin,
   // register writes
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_wr_data
);

   localparam int IDX_W = BINS > 1 ? $clog2(BINS) : 1;

   state_type            state_ff, state_in;
   logic [DATA_W-1:0]    mask_bits_ff, min_photoz_ff, max_photoz_ff;
   logic [DATA_W-1:0]    hist_start_ff, bin_width_ff;
   logic [DATA_W-1:0]    weight_ff, weight_in;
   logic                 last_ff, last_in;
   logic [IDX_W-1:0]     bin_addr_ff, bin_addr_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [DATA_W-1:0]    frac_ff, frac_in;
   logic [ACC_W-1:0]     total_ff, total_in;

   logic                 take;
   logic                 keep_row;
   logic [DATA_W-1:0]    spec_offset;
   logic                 in_range;
   logic                 last_bin;
   logic                 total_zero;

   div_cmd_type          div_cmd;
   logic                 div_done;
   logic [DIV_Q_W-1:0]   div_q;
   store_cmd_type        store_cmd;
   logic [IDX_W-1:0]     rd_addr;
   logic [ACC_W-1:0]     rd_data;
   logic [ACC_W-1:0]     wr_data;

   whn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_q)
   );

   whn_bin_store #(.BINS(BINS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_addr (rd_addr),
      .wr_addr (bin_addr_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // row filter on the incoming request, plus bin range, last bin and zero total flags
   always_comb begin
      take        = start && (state_ff == ST_IDLE);
      spec_offset = req_spec_z - hist_start_ff;
      keep_row    = (req_weight != '0)
                 && ((req_flag_bits & mask_bits_ff) == '0)
                 && (req_photo_z >= min_photoz_ff)
                 && (req_photo_z <= max_photoz_ff)
                 && (bin_width_ff != '0)
                 && (req_spec_z >= hist_start_ff);
      in_range    = div_q < DIV_Q_W'(BINS);
      last_bin    = k_ff == IDX_W'(BINS - 1);
      total_zero  = total_ff == '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (keep_row) state_in = ST_ROW_DIV;
               else if (req_last_item) state_in = ST_OUT_READ;
            end
         end
         ST_ROW_DIV: begin
            if (div_done) begin
               if (in_range) state_in = ST_ROW_ADD;
               else if (last_ff) state_in = ST_OUT_READ;
               else state_in = ST_IDLE;
            end
         end
         ST_ROW_ADD:  state_in = last_ff ? ST_OUT_READ : ST_IDLE;
         ST_OUT_READ: state_in = ST_OUT_LOAD;
         ST_OUT_LOAD: state_in = total_zero ? ST_OUT_SEND : ST_OUT_DIV;
         ST_OUT_DIV: begin
            if (div_done) state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: state_in = last_bin ? ST_IDLE : ST_OUT_READ;
         default:     state_in = ST_IDLE;
      endcase
   end

   // divider and store commands
   always_comb begin
      div_cmd   = '0;
      store_cmd = '0;
      rd_addr   = k_ff;
      wr_data   = sat_add(rd_data, weight_ff);
      case (state_ff)
         ST_IDLE: begin
            if (take && keep_row) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = {1'b0, spec_offset};
               div_cmd.divisor  = {{(ACC_W-DATA_W){1'b0}}, bin_width_ff};
            end
         end
         ST_ROW_DIV: begin
            rd_addr         = div_q[IDX_W-1:0];
            store_cmd.rd_en = div_done && in_range;
         end
         ST_ROW_ADD:  store_cmd.wr_en = 1'b1;
         ST_OUT_READ: store_cmd.rd_en = 1'b1;
         ST_OUT_LOAD: begin
            // sum * 2^16 / total: half the sum as remainder, its low bit then zeros
            if (!total_zero) begin
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = {1'b0, rd_data[ACC_W-1:1]};
               div_cmd.dividend = {rd_data[0], {(DIV_Q_W-1){1'b0}}};
               div_cmd.divisor  = total_ff;
            end
         end
         ST_OUT_SEND: store_cmd.clear = last_bin;
         default: ;
      endcase
   end

   // datapath register updates
   always_comb begin
      weight_in   = weight_ff;
      last_in     = last_ff;
      bin_addr_in = bin_addr_ff;
      k_in        = k_ff;
      frac_in     = frac_ff;
      total_in    = total_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               weight_in = req_weight;
               last_in   = req_last_item;
            end
         end
         ST_ROW_DIV: begin
            if (div_done) bin_addr_in = div_q[IDX_W-1:0];
         end
         ST_ROW_ADD:  total_in = sat_add(total_ff, weight_ff);
         ST_OUT_LOAD: begin
            if (total_zero) frac_in = '0;
         end
         ST_OUT_DIV: begin
            if (div_done) begin
               frac_in = div_q[DIV_Q_W-1] ? {DATA_W{1'b1}} : div_q[DATA_W-1:0];
            end
         end
         ST_OUT_SEND: begin
            if (last_bin) begin
               k_in     = '0;
               total_in = '0;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         k_ff          <= '0;
         total_ff      <= '0;
         mask_bits_ff  <= MASK_BITS_RESET;
         min_photoz_ff <= MIN_PHOTOZ_RESET;
         max_photoz_ff <= MAX_PHOTOZ_RESET;
         hist_start_ff <= HIST_START_RESET;
         bin_width_ff  <= BIN_WIDTH_RESET;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         total_ff <= total_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MASK_BITS:  mask_bits_ff  <= csr_wr_data;
               CSR_MIN_PHOTOZ: min_photoz_ff <= csr_wr_data;
               CSR_MAX_PHOTOZ: max_photoz_ff <= csr_wr_data;
               CSR_HIST_START: hist_start_ff <= csr_wr_data;
               CSR_BIN_WIDTH:  bin_width_ff  <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      weight_ff   <= weight_in;
      last_ff     <= last_in;
      bin_addr_ff <= bin_addr_in;
      frac_ff     <= frac_in;
   end

   // result ports
   assign busy           = state_ff != ST_IDLE;
   assign rsp_strobe     = state_ff == ST_OUT_SEND;
   assign rsp_bin_index  = BIN_INDEX_W'(k_ff);
   assign rsp_fraction   = frac_ff;
   assign rsp_total_zero = total_zero;
   assign rsp_last_bin   = last_bin;

   // results come only while busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // an accepted last row makes the block busy (a dropped plain row would not)
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_item |=> busy)
      else $error("last row accepted but block not busy");

   // the final bin returns the block to idle with an empty total
   a_last_bin_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_bin |=> !busy && total_ff == '0)
      else $error("block not idle and cleared after final bin");

   // a zero total forces zero fractions
   a_zero_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_total_zero |-> rsp_fraction == '0)
      else $error("nonzero fraction with zero total");

endmodule
